@@ design/vap_pkg.sv @@
// Package for the vibrance adjustment pixel pipeline.
// Holds pixel and gain types plus the fixed-point constants; depends on nothing.
`timescale 1ns / 1ps

package vap_pkg;

    localparam int PIX_W   = 8;
    localparam int GAIN_W  = 11;
    localparam int NUM_CH  = 3;

    typedef logic [PIX_W-1:0]         pix_t;
    typedef logic signed [GAIN_W-1:0] gain_t;

    // Channel positions inside the per-pixel arrays.
    localparam int CH_BLUE  = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_RED   = 2;

    // Denominator 3 * 127 * 256 of the adjust term.
    localparam logic [16:0] VIB_DEN = 17'd97536;
    // The same denominator without its factor of 256.
    localparam logic [8:0]  VIB_DEN_HI = 9'd381;
    // floor(n / 381) == (n * VIB_RECIP) >> VIB_RECIP_SH for every n below 140985.
    localparam logic [15:0] VIB_RECIP    = 16'd44035;
    localparam int          VIB_RECIP_SH = 24;
    // Numerators at or above 255 * VIB_DEN give 255 once rounded and clamped.
    localparam logic signed [28:0] VIB_SAT_NUM = 29'sd24871680;
    // Half of VIB_DEN, the rounding tie point for the remainder.
    localparam logic [16:0] VIB_HALF = 17'd48768;

    // Number of register stages in the pipeline, one valid bit per stage.
    localparam int VAP_LATENCY = 7;

endpackage

@@ design/vap_pixel_ifs.sv @@
// Handshake interfaces for incoming and adjusted pixels.
// Both carry valid, ready and a blue, green, red payload; they use vap_pkg types.
`timescale 1ns / 1ps

interface vap_in_if;
    import vap_pkg::*;

    logic valid;
    logic ready;
    pix_t blue_in;
    pix_t green_in;
    pix_t red_in;

    modport source (output valid, output blue_in, output green_in, output red_in,
                    input ready);
    modport sink   (input valid, input blue_in, input green_in, input red_in,
                    output ready);
endinterface

interface vap_out_if;
    import vap_pkg::*;

    logic valid;
    logic ready;
    pix_t blue_out;
    pix_t green_out;
    pix_t red_out;

    modport source (output valid, output blue_out, output green_out, output red_out,
                    input ready);
    modport sink   (input valid, input blue_out, input green_out, input red_out,
                    output ready);
endinterface

@@ design/vibrance_adjust_pixel.sv @@
// Vibrance adjustment of one blue, green, red pixel per request, seven register stages.
// Throughput is one pixel per cycle; a stall on the output freezes all seven stages.
// Reset clears every stage valid bit and sets the gain register to zero.
// Depends on vap_pkg and the vap_in_if / vap_out_if interfaces.
`timescale 1ns / 1ps

module vibrance_adjust_pixel (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  vap_pkg::gain_t cfg_wdata,
    vap_in_if.sink         pixel,
    vap_out_if.source      adjusted
);
    import vap_pkg::*;

    // The math per channel c, with M the largest channel and S the sum:
    //   num = c * 97536 - (M - c) * (3M - S) * gain
    //   out = sat(round_half_even(num / 97536))
    // Stage 1 finds M and 3M - S, stage 2 forms (M - c) * (3M - S), stage 3
    // applies the gain, stage 4 builds the numerator, stage 5 divides by a
    // reciprocal multiply, stage 6 forms the remainder and stage 7 rounds and
    // saturates into the output register.

    gain_t gain_reg;

    // The whole pipeline moves together; it only holds while the result in
    // the output register is waiting to be taken.
    logic advance;
    assign advance = !adjusted.valid || adjusted.ready;
    assign pixel.ready = advance;

    logic [VAP_LATENCY-1:0] vld_reg;
    logic [VAP_LATENCY-1:0] vld_next;

    // Stage registers.
    logic [NUM_CH-1:0][PIX_W-1:0] c1_reg, c2_reg, c3_reg;
    logic [PIX_W-1:0]             max1_reg;
    logic [8:0]                   spread1_reg;
    logic [NUM_CH-1:0][16:0]      dist2_reg;
    logic [NUM_CH-1:0][27:0]      adj3_reg;
    logic [NUM_CH-1:0][28:0]      num4_reg;
    logic [NUM_CH-1:0][7:0]       quo5_reg, quo6_reg;
    logic [NUM_CH-1:0][16:0]      hi5_reg;
    logic [NUM_CH-1:0][7:0]       lo5_reg, lo6_reg;
    logic [NUM_CH-1:0]            neg5_reg, neg6_reg, sat5_reg, sat6_reg;
    logic [NUM_CH-1:0][8:0]       rem6_reg;
    logic [NUM_CH-1:0][PIX_W-1:0] res7_reg;

    // Next values.
    logic [NUM_CH-1:0][PIX_W-1:0] c1_next;
    logic [PIX_W-1:0]             max1_next;
    logic [8:0]                   spread1_next;
    logic [NUM_CH-1:0][16:0]      dist2_next;
    logic [NUM_CH-1:0][27:0]      adj3_next;
    logic [NUM_CH-1:0][28:0]      num4_next;
    logic [NUM_CH-1:0][7:0]       quo5_next;
    logic [NUM_CH-1:0][16:0]      hi5_next;
    logic [NUM_CH-1:0][7:0]       lo5_next;
    logic [NUM_CH-1:0]            neg5_next, sat5_next;
    logic [NUM_CH-1:0][8:0]       rem6_next;
    logic [NUM_CH-1:0][PIX_W-1:0] res7_next;

    assign vld_next = {vld_reg[VAP_LATENCY-2:0], pixel.valid};

    // Stage 1: largest channel and 3M - S, which never exceeds 510.
    always_comb
    begin
        logic [PIX_W-1:0] bg_max;
        logic [9:0]       sum;
        logic [9:0]       triple;
        logic [9:0]       spread;
        c1_next[CH_BLUE]  = pixel.blue_in;
        c1_next[CH_GREEN] = pixel.green_in;
        c1_next[CH_RED]   = pixel.red_in;
        bg_max    = (pixel.green_in > pixel.blue_in) ? pixel.green_in : pixel.blue_in;
        max1_next = (pixel.red_in > bg_max) ? pixel.red_in : bg_max;
        sum    = 10'(pixel.blue_in) + 10'(pixel.green_in) + 10'(pixel.red_in);
        triple = 10'(max1_next) + 10'({max1_next, 1'b0});
        spread = triple - sum;
        spread1_next = spread[8:0];
    end

    // Stage 2: distance to the maximum times the spread; zero for a maximal channel.
    always_comb
    begin
        logic [PIX_W-1:0] gap;
        for (int i = 0; i < NUM_CH; i++)
        begin
            gap           = max1_reg - c1_reg[i];
            dist2_next[i] = 17'(gap) * 17'(spread1_reg);
        end
    end

    // Stage 3: scale by the signed gain; the magnitude stays below 2^27.
    always_comb
    begin
        logic signed [28:0] prod;
        for (int i = 0; i < NUM_CH; i++)
        begin
            prod         = 29'($signed({1'b0, dist2_reg[i]})) * 29'(gain_reg);
            adj3_next[i] = prod[27:0];
        end
    end

    // Stage 4: full numerator in 29-bit two's complement.
    always_comb
    begin
        logic [24:0]        base;
        logic signed [28:0] num;
        for (int i = 0; i < NUM_CH; i++)
        begin
            base         = 25'(c3_reg[i]) * 25'(VIB_DEN);
            num          = $signed({4'b0000, base}) - 29'($signed(adj3_reg[i]));
            num4_next[i] = num;
        end
    end

    // Stage 5: classify the numerator and divide its upper part by 381.
    // Out of the saturated and non-positive ranges the numerator fits 25 bits.
    always_comb
    begin
        logic signed [28:0] num;
        logic [32:0]        prod;
        for (int i = 0; i < NUM_CH; i++)
        begin
            num          = $signed(num4_reg[i]);
            neg5_next[i] = (num <= 29'sd0);
            sat5_next[i] = (num >= VIB_SAT_NUM);
            hi5_next[i]  = num4_reg[i][24:8];
            lo5_next[i]  = num4_reg[i][7:0];
            prod         = 33'(hi5_next[i]) * 33'(VIB_RECIP);
            quo5_next[i] = prod[VIB_RECIP_SH+7:VIB_RECIP_SH];
        end
    end

    // Stage 6: remainder of the upper part, below 381.
    always_comb
    begin
        logic [16:0] back;
        logic [16:0] rem;
        for (int i = 0; i < NUM_CH; i++)
        begin
            back         = 17'(quo5_reg[i]) * 17'(VIB_DEN_HI);
            rem          = hi5_reg[i] - back;
            rem6_next[i] = rem[8:0];
        end
    end

    // Stage 7: round half to even, then clamp. Below the saturation point the
    // rounded quotient never passes 255, so the increment cannot wrap.
    always_comb
    begin
        logic [16:0] rem;
        logic        round_up;
        for (int i = 0; i < NUM_CH; i++)
        begin
            rem      = {rem6_reg[i], lo6_reg[i]};
            round_up = (rem > VIB_HALF) || ((rem == VIB_HALF) && quo6_reg[i][0]);
            if (neg6_reg[i])
            begin
                res7_next[i] = '0;
            end
            else if (sat6_reg[i])
            begin
                res7_next[i] = '1;
            end
            else
            begin
                res7_next[i] = quo6_reg[i] + PIX_W'(round_up);
            end
        end
    end

    // Control state: gain register and the valid bit of every stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= '0;
            vld_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                gain_reg <= cfg_wdata;
            end
            if (advance)
            begin
                vld_reg <= vld_next;
            end
        end
    end

    // Datapath registers carry no reset; their valid bits qualify them.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            c1_reg      <= c1_next;
            max1_reg    <= max1_next;
            spread1_reg <= spread1_next;
            c2_reg      <= c1_reg;
            dist2_reg   <= dist2_next;
            c3_reg      <= c2_reg;
            adj3_reg    <= adj3_next;
            num4_reg    <= num4_next;
            quo5_reg    <= quo5_next;
            hi5_reg     <= hi5_next;
            lo5_reg     <= lo5_next;
            neg5_reg    <= neg5_next;
            sat5_reg    <= sat5_next;
            quo6_reg    <= quo5_reg;
            lo6_reg     <= lo5_reg;
            neg6_reg    <= neg5_reg;
            sat6_reg    <= sat5_reg;
            rem6_reg    <= rem6_next;
            res7_reg    <= res7_next;
        end
    end

    assign adjusted.valid     = vld_reg[VAP_LATENCY-1];
    assign adjusted.blue_out  = res7_reg[CH_BLUE];
    assign adjusted.green_out = res7_reg[CH_GREEN];
    assign adjusted.red_out   = res7_reg[CH_RED];

endmodule

@@ design/vap_checker.sv @@
// Port-level checker for vibrance_adjust_pixel and the bind that attaches it.
// Depends on vap_pkg for the pipeline depth and pixel type.
`timescale 1ns / 1ps

module vap_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input vap_pkg::pix_t blue_out,
    input vap_pkg::pix_t green_out,
    input vap_pkg::pix_t red_out
);
    import vap_pkg::*;

    // Requests accepted but not yet delivered.
    logic [3:0] inflight_reg;
    logic [3:0] inflight_next;

    always_comb
    begin
        inflight_next = inflight_reg + 4'(in_valid && in_ready) - 4'(out_valid && out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // A result is never shown without a request behind it.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (inflight_reg != 4'd0))
        else $error("result shown with no request in flight");

    // The pipeline never holds more requests than it has stages.
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 4'(VAP_LATENCY))
        else $error("more requests in flight than pipeline stages");

    // With the output register empty the block always takes a request.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while the output register is empty");

    // A stalled result holds its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(blue_out) && $stable(green_out) && $stable(red_out)))
        else $error("stalled result changed or dropped");

endmodule

bind vibrance_adjust_pixel vap_checker u_vap_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pixel.valid),
    .in_ready  (pixel.ready),
    .out_valid (adjusted.valid),
    .out_ready (adjusted.ready),
    .blue_out  (adjusted.blue_out),
    .green_out (adjusted.green_out),
    .red_out   (adjusted.red_out)
);
